>>> hw/rtl/bsff_pkg.sv
// Shared types, sizes, operation codes and helpers for the bitmap set/find-first block.
package bsff_pkg;

  localparam int MAX_BYTES = 32;
  localparam int ADDR_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int CFG_W     = 6;
  localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  // bit_index reaches 256 bits at most, so a find walks no more than 32 bytes
  localparam int SCAN_MAX  = (MAX_BYTES < 32) ? MAX_BYTES : 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  localparam logic [2:0] MODE_SET       = 3'd0;
  localparam logic [2:0] MODE_CLEAR     = 3'd1;
  localparam logic [2:0] MODE_TEST      = 3'd2;
  localparam logic [2:0] MODE_FIND_ONE  = 3'd3;
  localparam logic [2:0] MODE_FIND_ZERO = 3'd4;
  localparam logic [2:0] MODE_FILL      = 3'd5;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] bit_index;
    logic       fill_value;
  } in_word_t;

  typedef struct packed {
    logic       bit_value;
    logic       found;
    logic [7:0] found_index;
    logic       out_of_range;
  } out_word_t;

  // Position of the lowest set bit of a byte; 0 for an all-zero byte.
  function automatic logic [2:0] lowest_set(input logic [7:0] d);
    logic [2:0] pos;
    pos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (d[i]) pos = 3'(i);
    end
    return pos;
  endfunction

endpackage

>>> hw/rtl/bitmap_set_find_first.sv
// Bitmap set/clear/test/find-first/fill top level: length register, engine, output register.
// Set/clear/test pass a modify state; out of range and unused modes go straight to the result.
// Find reads one RAM byte a cycle, up to 32 bytes; fill writes every byte in use.
// One word at a time: next word taken the cycle after the result moves to the output register.
// Reset clears the bitmap at once through per-byte valid bits and sets bytes in use to 32.
module bitmap_set_find_first (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bsff_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bsff_pkg::out_word_t  out_data,
  input  logic                 cfg_we,
  input  logic [bsff_pkg::CFG_W-1:0] cfg_wdata
);

  logic [bsff_pkg::CFG_W-1:0] cfg_len_r;
  logic [bsff_pkg::CNT_W-1:0] nbytes;
  logic                       res_valid, res_ready;
  bsff_pkg::out_word_t        res_data;
  logic                       out_valid_r;
  bsff_pkg::out_word_t        out_data_r;

  // Saturate the length in use to the bitmap size.
  assign nbytes = (bsff_pkg::CMP_W'(cfg_len_r) > bsff_pkg::CMP_W'(bsff_pkg::MAX_BYTES))
                ? bsff_pkg::CNT_W'(bsff_pkg::MAX_BYTES)
                : bsff_pkg::CNT_W'(cfg_len_r);

  bsff_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .nbytes    (nbytes),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  assign res_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r   <= bsff_pkg::CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cfg_len_r <= cfg_wdata;
      if (res_valid && res_ready) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_data_r <= res_data;
  end

  a_no_found_and_oor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.found && out_data.out_of_range))
    else $error("found and out_of_range both set");

  a_ready_means_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !res_valid)
    else $error("input ready while engine holds a result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while engine busy");

  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.found) |->
      (bsff_pkg::CMP_W'(out_data.found_index[7:3]) < bsff_pkg::CMP_W'(nbytes)))
    else $error("found index beyond bytes in use");

endmodule

>>> hw/rtl/bsff_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/bsff_engine.sv
// Read-modify-write sequencer: bit ops, byte-serial find scan and fill sweep over the RAM.
module bsff_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [bsff_pkg::CNT_W-1:0]  nbytes,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bsff_pkg::in_word_t          in_data,
  output logic                        res_valid,
  input  logic                        res_ready,
  output bsff_pkg::out_word_t         res_data
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MOD  = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_FILL = 5'b01000,
    ST_RESP = 5'b10000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [bsff_pkg::ADDR_W-1:0]   ptr_r, ptr_nxt;
  bsff_pkg::in_word_t            op_r, op_nxt;
  bsff_pkg::out_word_t           res_r, res_nxt;
  logic [bsff_pkg::MAX_BYTES-1:0] vld_r;

  logic                          ram_we;
  logic [bsff_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [7:0]                    ram_wdata, ram_rdata;

  logic [bsff_pkg::CNT_W-1:0]    scan_len;
  logic [7:0]                    cur_byte, cand;
  logic                          last_ptr_scan, last_ptr_fill, accept;
  logic [bsff_pkg::ADDR_W-1:0]   ptr_inc;

  bsff_ram #(.WIDTH(8), .DEPTH(bsff_pkg::MAX_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state_r == ST_RESP);
  assign res_data  = res_r;

  assign scan_len = (bsff_pkg::CMP_W'(nbytes) > bsff_pkg::CMP_W'(bsff_pkg::SCAN_MAX))
                  ? bsff_pkg::CNT_W'(bsff_pkg::SCAN_MAX) : nbytes;

  assign ptr_inc       = bsff_pkg::ADDR_W'(bsff_pkg::CMP_W'(ptr_r) + bsff_pkg::CMP_W'(1));
  assign last_ptr_scan = (bsff_pkg::CMP_W'(ptr_r) + bsff_pkg::CMP_W'(1))
                         == bsff_pkg::CMP_W'(scan_len);
  assign last_ptr_fill = (bsff_pkg::CMP_W'(ptr_r) + bsff_pkg::CMP_W'(1))
                         == bsff_pkg::CMP_W'(nbytes);

  // Never-written entries read as zero, matching the cleared bitmap.
  assign cur_byte = vld_r[ptr_r] ? ram_rdata : 8'h00;
  assign cand     = (op_r.mode == bsff_pkg::MODE_FIND_ONE) ? cur_byte : ~cur_byte;

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    op_nxt    = op_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = op_r.fill_value ? 8'hFF : 8'h00;
    ram_raddr = ptr_inc;
    case (state_r)
      ST_IDLE: begin
        ram_raddr = bsff_pkg::ADDR_W'(in_data.bit_index[7:3]);
        if (accept) begin
          op_nxt  = in_data;
          res_nxt = '0;
          ptr_nxt = bsff_pkg::ADDR_W'(in_data.bit_index[7:3]);
          case (in_data.mode)
            bsff_pkg::MODE_SET, bsff_pkg::MODE_CLEAR, bsff_pkg::MODE_TEST: begin
              if (bsff_pkg::CMP_W'(in_data.bit_index[7:3]) >= bsff_pkg::CMP_W'(nbytes)) begin
                res_nxt.out_of_range = 1'b1;
                state_nxt = ST_RESP;
              end else begin
                state_nxt = ST_MOD;
              end
            end
            bsff_pkg::MODE_FIND_ONE, bsff_pkg::MODE_FIND_ZERO: begin
              ram_raddr = '0;
              ptr_nxt   = '0;
              state_nxt = (scan_len == '0) ? ST_RESP : ST_SCAN;
            end
            bsff_pkg::MODE_FILL: begin
              ptr_nxt   = '0;
              state_nxt = (nbytes == '0) ? ST_RESP : ST_FILL;
            end
            default: state_nxt = ST_RESP;
          endcase
        end
      end
      ST_MOD: begin
        res_nxt.bit_value = cur_byte[op_r.bit_index[2:0]];
        ram_waddr = ptr_r;
        if (op_r.mode == bsff_pkg::MODE_SET) begin
          ram_we    = 1'b1;
          ram_wdata = cur_byte | (8'h01 << op_r.bit_index[2:0]);
        end else if (op_r.mode == bsff_pkg::MODE_CLEAR) begin
          ram_we    = 1'b1;
          ram_wdata = cur_byte & ~(8'h01 << op_r.bit_index[2:0]);
        end
        state_nxt = ST_RESP;
      end
      ST_SCAN: begin
        if (cand != 8'h00) begin
          res_nxt.found       = 1'b1;
          res_nxt.found_index = 8'({ptr_r, bsff_pkg::lowest_set(cand)});
          state_nxt = ST_RESP;
        end else if (last_ptr_scan) begin
          state_nxt = ST_RESP;
        end else begin
          ptr_nxt = ptr_inc;
        end
      end
      ST_FILL: begin
        ram_we = 1'b1;
        if (last_ptr_fill) state_nxt = ST_RESP;
        else ptr_nxt = ptr_inc;
      end
      ST_RESP: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) vld_r[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    op_r  <= op_nxt;
    res_r <= res_nxt;
  end

endmodule

>>> tb/tb_bitmap_set_find_first.sv
// Self-checking testbench for bitmap_set_find_first: shadow bitmap predictor and result scoreboard.
class bitmap_scoreboard;
  logic [7:0] shadow [bsff_pkg::MAX_BYTES];
  logic [bsff_pkg::CFG_W-1:0] length_reg;
  bsff_pkg::out_word_t expected_q[$];
  int errors;

  function new();
    for (int i = 0; i < bsff_pkg::MAX_BYTES; i++) shadow[i] = 8'h00;
    length_reg = bsff_pkg::CFG_RESET;
    errors = 0;
  endfunction

  function void set_length(logic [bsff_pkg::CFG_W-1:0] v);
    length_reg = v;
  endfunction

  function int live_bytes();
    return (length_reg > bsff_pkg::MAX_BYTES) ? bsff_pkg::MAX_BYTES : int'(length_reg);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Apply one accepted word to the shadow bitmap and queue the word it must produce.
  function void note_request(bsff_pkg::in_word_t w);
    bsff_pkg::out_word_t r;
    int nbytes;
    int byte_sel;
    int limit;
    int want;
    r = '0;
    nbytes = live_bytes();
    case (w.mode)
      bsff_pkg::MODE_SET, bsff_pkg::MODE_CLEAR, bsff_pkg::MODE_TEST: begin
        byte_sel = int'(w.bit_index >> 3);
        if (byte_sel >= nbytes) begin
          r.out_of_range = 1'b1;
        end else begin
          r.bit_value = shadow[byte_sel][w.bit_index[2:0]];
          if (w.mode == bsff_pkg::MODE_SET) shadow[byte_sel][w.bit_index[2:0]] = 1'b1;
          else if (w.mode == bsff_pkg::MODE_CLEAR) shadow[byte_sel][w.bit_index[2:0]] = 1'b0;
        end
      end
      bsff_pkg::MODE_FIND_ONE, bsff_pkg::MODE_FIND_ZERO: begin
        want = (w.mode == bsff_pkg::MODE_FIND_ONE) ? 1 : 0;
        limit = nbytes * 8;
        if (limit > 256) limit = 256;
        for (int k = 0; k < limit && !r.found; k++) begin
          if (shadow[k >> 3][k % 8] == want) begin
            r.found = 1'b1;
            r.found_index = 8'(k);
          end
        end
      end
      bsff_pkg::MODE_FILL: begin
        for (int i = 0; i < nbytes; i++) shadow[i] = {8{w.fill_value}};
      end
      default: ;
    endcase
    expected_q.push_back(r);
  endfunction

  function void compare_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endfunction

  function void check_result(bsff_pkg::out_word_t got);
    bsff_pkg::out_word_t exp_w;
    if (expected_q.size() == 0) begin
      $error("result word %h with nothing expected", got);
      errors++;
      return;
    end
    exp_w = expected_q.pop_front();
    compare_field("bit_value", 8'(exp_w.bit_value), 8'(got.bit_value));
    compare_field("found", 8'(exp_w.found), 8'(got.found));
    compare_field("found_index", exp_w.found_index, got.found_index);
    compare_field("out_of_range", 8'(exp_w.out_of_range), 8'(got.out_of_range));
  endfunction
endclass

module tb_bitmap_set_find_first;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 95;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  // Codes with no operation behind them
  localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  bsff_pkg::in_word_t         in_data;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  bsff_pkg::out_word_t        out_data;
  logic                       cfg_we;
  logic [bsff_pkg::CFG_W-1:0] cfg_wdata;
  logic                       hold_request = 1'b0;

  bitmap_scoreboard sb = new();

  bitmap_set_find_first uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bsff_pkg::in_word_t mk_word(logic [2:0] mode, logic [7:0] idx, logic fill);
    bsff_pkg::in_word_t w;
    w.mode = mode;
    w.bit_index = idx;
    w.fill_value = fill;
    return w;
  endfunction

  // Mostly bit operations inside the bytes in use, then finds, a few fills and raw noise.
  function automatic bsff_pkg::in_word_t random_word();
    bsff_pkg::in_word_t w;
    int pick;
    int span;
    w.mode = 3'($urandom_range(0, 7));
    w.bit_index = 8'($urandom);
    w.fill_value = 1'($urandom);
    pick = $urandom_range(0, 99);
    span = sb.live_bytes() * 8;
    if (pick < 60) begin
      w.mode = (pick < 25) ? bsff_pkg::MODE_SET
             : (pick < 45) ? bsff_pkg::MODE_CLEAR : bsff_pkg::MODE_TEST;
      if (span > 0 && pick % 10 != 0) w.bit_index = 8'($urandom_range(0, span - 1));
    end else if (pick < 85) begin
      w.mode = (pick < 72) ? bsff_pkg::MODE_FIND_ONE : bsff_pkg::MODE_FIND_ZERO;
    end else if (pick < 90) begin
      w.mode = bsff_pkg::MODE_FILL;
    end
    return w;
  endfunction

  // Call at a rising edge; returns at the edge that takes the word.
  task automatic send_word(input bsff_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_request(w);
  endtask

  task automatic write_length(input logic [bsff_pkg::CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_length(v);
  endtask

  task automatic send_stream(input int count, input int gap_max);
    int burst_left;
    int gap;
    burst_left = 0;
    for (int n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      send_word(random_word());
      burst_left--;
    end
  endtask

  initial begin : result_sink
    int stall_kind;
    int stall_left;
    int hold_left;
    bit hold_done;
    stall_kind = 0;
    stall_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (stall_left == 0) begin
        stall_kind = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 96);
      end
      stall_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (stall_kind)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [bsff_pkg::CFG_W-1:0] lengths [10];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty bitmap, edges of the index range, fill and unused codes at the reset length.
    send_word(mk_word(bsff_pkg::MODE_FIND_ONE, 8'd0, 1'b0));
    send_word(mk_word(bsff_pkg::MODE_FIND_ZERO, 8'd255, 1'b1));
    send_word(mk_word(bsff_pkg::MODE_TEST, 8'd255, 1'b0));
    send_word(mk_word(bsff_pkg::MODE_SET, 8'd0, 1'b0));
    send_word(mk_word(bsff_pkg::MODE_SET, 8'd255, 1'b1));
    send_word(mk_word(bsff_pkg::MODE_SET, 8'd0, 1'b1));
    send_word(mk_word(bsff_pkg::MODE_TEST, 8'd255, 1'b0));
    send_word(mk_word(bsff_pkg::MODE_FIND_ONE, 8'd255, 1'b0));
    send_word(mk_word(bsff_pkg::MODE_CLEAR, 8'd0, 1'b0));
    send_word(mk_word(bsff_pkg::MODE_FIND_ONE, 8'd0, 1'b1));
    send_word(mk_word(bsff_pkg::MODE_FILL, 8'd0, 1'b1));
    send_word(mk_word(bsff_pkg::MODE_FIND_ZERO, 8'd0, 1'b0));
    send_word(mk_word(bsff_pkg::MODE_CLEAR, 8'd100, 1'b0));
    send_word(mk_word(bsff_pkg::MODE_FIND_ZERO, 8'd0, 1'b0));
    send_word(mk_word(MODE_UNUSED_LO, 8'd255, 1'b1));
    send_word(mk_word(MODE_UNUSED_HI, 8'd170, 1'b1));
    send_word(mk_word(bsff_pkg::MODE_FILL, 8'd255, 1'b0));
    send_word(mk_word(bsff_pkg::MODE_FIND_ONE, 8'd0, 1'b0));

    // No bytes in use: everything misses.
    write_length(6'd0);
    send_word(mk_word(bsff_pkg::MODE_SET, 8'd0, 1'b0));
    send_word(mk_word(bsff_pkg::MODE_FIND_ZERO, 8'd0, 1'b0));
    send_word(mk_word(bsff_pkg::MODE_FILL, 8'd0, 1'b1));

    // Length above the array saturates.
    write_length(6'd63);
    send_word(mk_word(bsff_pkg::MODE_TEST, 8'd255, 1'b0));
    send_word(mk_word(bsff_pkg::MODE_FIND_ZERO, 8'd0, 1'b0));

    write_length(6'd1);
    send_word(mk_word(bsff_pkg::MODE_SET, 8'd8, 1'b0));
    send_word(mk_word(bsff_pkg::MODE_SET, 8'd7, 1'b0));
    send_word(mk_word(bsff_pkg::MODE_FIND_ONE, 8'd0, 1'b0));

    lengths[0] = 6'd32;
    lengths[1] = 6'd1;
    lengths[2] = 6'(($urandom_range(1, 32)));
    lengths[3] = 6'd32;
    lengths[4] = 6'd0;
    lengths[5] = 6'd63;
    lengths[6] = 6'd5;
    lengths[7] = 6'd33;
    lengths[8] = 6'($urandom_range(0, 63));
    lengths[9] = 6'd16;
    for (int p = 0; p < 10; p++) begin
      write_length(lengths[p]);
      // Stall the result side for a long stretch while words keep coming.
      if (p == 3) hold_request <= 1'b1;
      send_stream(PHASE_ITEMS, (p % 3 == 1) ? 0 : 6);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
